FILE: src/taiir_pkg.sv
// Package for the three-axis fourth-order IIR lowpass core.
// Holds payload word types, fixed-point constants, coefficient tables and MAC control types.
// No dependencies.
`default_nettype none

package taiir_pkg;

   localparam int AXIS_COUNT = 3;
   localparam int SAMPLE_W   = 16;
   localparam int HIST_W     = 40;
   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 28;
   localparam int OPND_W     = 21;
   localparam int PROD_W     = OPND_W + COEF_W;
   localparam int SPLIT_W    = 20;
   localparam int TAP_MAX    = 8;
   localparam int TAP_IDX_W  = $clog2(TAP_MAX + 1);

   localparam logic signed [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
   localparam logic signed [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Feed-forward taps in Q4.28; higher taps are zero.
   localparam logic signed [COEF_W-1:0] COEF_B [0:TAP_MAX] = '{
      32'sd49182, 32'sd196727, 32'sd295090, 32'sd196727, 32'sd49182,
      32'sd0, 32'sd0, 32'sd0, 32'sd0};

   // Feedback taps already negated, Q4.28; tap zero is never used.
   localparam logic signed [COEF_W-1:0] NEG_COEF_A [0:TAP_MAX] = '{
      32'sd0, 32'sd897666375, -32'sd1137861378, 32'sd646753048, -32'sd138909497,
      32'sd0, 32'sd0, 32'sd0, 32'sd0};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x_sample;
      logic signed [SAMPLE_W-1:0] y_sample;
      logic signed [SAMPLE_W-1:0] z_sample;
      logic                       send_enable;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x_filtered;
      logic signed [SAMPLE_W-1:0] y_filtered;
      logic signed [SAMPLE_W-1:0] z_filtered;
   } rsp_type;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_SPLIT,
      SHIFT_FRAC
   } shift_type;

   typedef struct packed {
      logic      issue;
      logic      clear;
      shift_type shift;
   } mac_ctrl_type;

endpackage

`default_nettype wire

FILE: src/taiir_mac.sv
// Shared multiply-accumulate unit of the IIR lowpass core.
// A registered 21 x 32 signed multiplier feeding a wide shifted accumulator.
// Depends on taiir_pkg.
`default_nettype none

module taiir_mac #(
   parameter int HISTORY_FRACTION_BITS = 16,
   parameter int ACC_W                 = 77
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire taiir_pkg::mac_ctrl_type         ctrl,
   input  wire logic signed [taiir_pkg::OPND_W-1:0] op_a,
   input  wire logic signed [taiir_pkg::COEF_W-1:0] op_c,
   output logic signed [ACC_W-1:0]              acc
);
   import taiir_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   shift_type                shift_ff;
   logic                     valid_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_ff;

   assign prod_in  = op_a * op_c;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      unique case (shift_ff)
         SHIFT_NONE:  addend = prod_ext;
         SHIFT_SPLIT: addend = prod_ext <<< SPLIT_W;
         SHIFT_FRAC:  addend = prod_ext <<< HISTORY_FRACTION_BITS;
         default:     addend = prod_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.issue;
      end
      prod_ff  <= prod_in;
      shift_ff <= ctrl.shift;
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (valid_ff) begin
         acc_ff <= acc_ff + addend;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: src/three_axis_iir_lowpass_core.sv
// A new word is taken only after the previous one has been fully processed, since the
// single shared multiplier takes 3*FILTER_ORDER+1 products per axis in turn.
// req_ready is high only while the sequencer is idle; a finished result waits in its own register.
// Reset is synchronous and clears the sequencer, the output valid and all filter history.
`default_nettype none

module three_axis_iir_lowpass_core #(
   parameter int FILTER_ORDER          = 4,
   parameter int HISTORY_FRACTION_BITS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire taiir_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output taiir_pkg::rsp_type  rsp_data
);
   import taiir_pkg::*;

   // Accumulator is wide enough for every product, shifted, summed over all taps.
   localparam int ACC_W  = HIST_W + COEF_W + $clog2(2*FILTER_ORDER + 2) + 1;
   localparam int QW     = ACC_W - COEF_FRAC;
   localparam int OW     = HIST_W - HISTORY_FRACTION_BITS;
   localparam int AX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int TAP_W  = $clog2(FILTER_ORDER + 1);
   localparam int HIDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
   localparam logic [AX_W-1:0]  AX_LAST  = AX_W'(AXIS_COUNT - 1);
   localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(FILTER_ORDER);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_RESOLVE,
      S_UPDATE,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [AX_W-1:0]            ax_ff;
   logic [TAP_W-1:0]           tap_ff;
   logic [1:0]                 sub_ff;
   req_type                    req_ff;
   logic signed [HIST_W-1:0]   ynew_ff;
   logic signed [HIST_W-1:0]   ynew_in;
   logic signed [SAMPLE_W-1:0] res_ff [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] res_in;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   // Per-axis delay lines: index zero holds the most recent item.
   logic signed [SAMPLE_W-1:0] xh_ff [AXIS_COUNT][FILTER_ORDER];
   logic signed [HIST_W-1:0]   yh_ff [AXIS_COUNT][FILTER_ORDER];

   logic signed [SAMPLE_W-1:0] sample [AXIS_COUNT];
   logic [HIDX_W-1:0]          hidx;
   logic signed [SAMPLE_W-1:0] xh_rd;
   logic signed [HIST_W-1:0]   yh_rd;
   mac_ctrl_type               mac_ctrl;
   logic signed [OPND_W-1:0]   op_a;
   logic signed [COEF_W-1:0]   op_c;
   logic signed [ACC_W-1:0]    acc;

   logic signed [QW-1:0]       q_floor;
   logic signed [QW-1:0]       q_trunc;
   logic                       q_up;
   logic                       q_fits;
   logic signed [OW-1:0]       o_floor;
   logic signed [OW-1:0]       o_trunc;
   logic                       o_up;
   logic                       o_fits;

   assign sample[0] = req_ff.x_sample;
   assign sample[1] = req_ff.y_sample;
   assign sample[2] = req_ff.z_sample;

   // ------------------------------------------------------------------
   // Operand selection. Each axis runs x*b0, then for every tap i the
   // feed-forward product, and the feedback product split into a low
   // unsigned half and a high signed half of the 40-bit history value.
   // Input terms are shifted up by the history fraction so that they
   // line up with the feedback terms in the accumulator.
   // ------------------------------------------------------------------
   assign hidx  = HIDX_W'(tap_ff - TAP_W'(1));
   assign xh_rd = xh_ff[ax_ff][hidx];
   assign yh_rd = yh_ff[ax_ff][hidx];

   always_comb begin
      mac_ctrl.issue = (state_ff == S_MAC);
      mac_ctrl.clear = (state_ff == S_IDLE) || (state_ff == S_UPDATE);
      priority if (tap_ff == '0) begin
         op_a           = {{(OPND_W-SAMPLE_W){sample[ax_ff][SAMPLE_W-1]}}, sample[ax_ff]};
         op_c           = COEF_B[TAP_IDX_W'(tap_ff)];
         mac_ctrl.shift = SHIFT_FRAC;
      end else if (sub_ff == 2'd0) begin
         op_a           = {{(OPND_W-SAMPLE_W){xh_rd[SAMPLE_W-1]}}, xh_rd};
         op_c           = COEF_B[TAP_IDX_W'(tap_ff)];
         mac_ctrl.shift = SHIFT_FRAC;
      end else if (sub_ff == 2'd1) begin
         op_a           = {1'b0, yh_rd[SPLIT_W-1:0]};
         op_c           = NEG_COEF_A[TAP_IDX_W'(tap_ff)];
         mac_ctrl.shift = SHIFT_NONE;
      end else begin
         op_a           = {yh_rd[HIST_W-1], yh_rd[HIST_W-1:SPLIT_W]};
         op_c           = NEG_COEF_A[TAP_IDX_W'(tap_ff)];
         mac_ctrl.shift = SHIFT_SPLIT;
      end
   end

   taiir_mac #(
      .HISTORY_FRACTION_BITS (HISTORY_FRACTION_BITS),
      .ACC_W                 (ACC_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_c  (op_c),
      .acc   (acc)
   );

   // ------------------------------------------------------------------
   // New history value: the accumulator divided by 2^28, truncated
   // toward zero (a negative sum with a non-zero fraction is rounded up)
   // and saturated to signed 40 bits.
   // ------------------------------------------------------------------
   assign q_floor = acc[ACC_W-1:COEF_FRAC];
   assign q_up    = acc[ACC_W-1] & (|acc[COEF_FRAC-1:0]);
   assign q_trunc = q_floor + QW'(q_up);
   assign q_fits  = (&q_trunc[QW-1:HIST_W-1]) | ~(|q_trunc[QW-1:HIST_W-1]);
   assign ynew_in = q_fits ? q_trunc[HIST_W-1:0] : (q_trunc[QW-1] ? HIST_MIN : HIST_MAX);

   // Result value: the history value with its fraction dropped toward
   // zero, saturated to signed 16 bits.
   assign o_floor = ynew_ff[HIST_W-1:HISTORY_FRACTION_BITS];
   assign o_up    = ynew_ff[HIST_W-1] & (|ynew_ff[HISTORY_FRACTION_BITS-1:0]);
   assign o_trunc = o_floor + OW'(o_up);
   assign o_fits  = (&o_trunc[OW-1:SAMPLE_W-1]) | ~(|o_trunc[OW-1:SAMPLE_W-1]);
   assign res_in  = o_fits ? o_trunc[SAMPLE_W-1:0] : (o_trunc[OW-1] ? SAMPLE_MIN : SAMPLE_MAX);

   // ------------------------------------------------------------------
   // Sequencer. Axes are filtered one after another; within an axis the
   // tap counter and the sub-step counter walk through the products.
   // The history is updated for every word, but the result word is only
   // loaded into the output register when send_enable was set.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ax_ff        <= '0;
         tap_ff       <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A word taken while the next one is being loaded keeps valid high.
         if (rsp_valid_ff && rsp_ready &&
             !(state_ff == S_DONE && req_ff.send_enable)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  ax_ff    <= '0;
                  tap_ff   <= '0;
                  sub_ff   <= '0;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               if (tap_ff == '0) begin
                  tap_ff <= TAP_W'(1);
                  sub_ff <= '0;
               end else if (sub_ff == 2'd2) begin
                  sub_ff <= '0;
                  if (tap_ff == TAP_LAST) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     tap_ff <= tap_ff + TAP_W'(1);
                  end
               end else begin
                  sub_ff <= sub_ff + 2'd1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_RESOLVE;
            end
            S_RESOLVE: begin
               ynew_ff  <= ynew_in;
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               res_ff[ax_ff] <= res_in;
               tap_ff        <= '0;
               sub_ff        <= '0;
               if (ax_ff == AX_LAST) begin
                  state_ff <= S_DONE;
               end else begin
                  ax_ff    <= ax_ff + AX_W'(1);
                  state_ff <= S_MAC;
               end
            end
            S_DONE: begin
               if (!req_ff.send_enable) begin
                  state_ff <= S_IDLE;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.x_filtered <= res_ff[0];
                  rsp_data_ff.y_filtered <= res_ff[1];
                  rsp_data_ff.z_filtered <= res_ff[2];
                  state_ff                <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // History shift for the axis just finished.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            for (int t = 0; t < FILTER_ORDER; t++) begin
               xh_ff[a][t] <= '0;
               yh_ff[a][t] <= '0;
            end
         end
      end else if (state_ff == S_UPDATE) begin
         xh_ff[ax_ff][0] <= sample[ax_ff];
         yh_ff[ax_ff][0] <= ynew_ff;
         for (int t = 1; t < FILTER_ORDER; t++) begin
            xh_ff[ax_ff][t] <= xh_ff[ax_ff][t-1];
            yh_ff[ax_ff][t] <= yh_ff[ax_ff][t-1];
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A result word only appears at the end of a word that asked for one.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == S_DONE) && $past(req_ff.send_enable)))
      else $error("result word raised outside the final step or without send_enable");

   // The tap counter never walks past the filter order.
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (tap_ff <= TAP_LAST && sub_ff != 2'd3))
      else $error("tap sequencer out of range");

   // The history only moves in the update step.
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_UPDATE) |=> ($stable(yh_ff[0][0]) && $stable(xh_ff[0][0])))
      else $error("filter history changed outside the update step");

   // A new word is only taken once the previous one has fully finished.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MAC && ax_ff == '0 && tap_ff == '0))
      else $error("word accepted without restarting the sequencer");
`endif

endmodule

`default_nettype wire

FILE: verif/three_axis_iir_lowpass_core_tb.sv
// Self-checking testbench for the three-axis fourth-order IIR lowpass core.
// A bit-exact fixed-point filter model predicts every result word; needs only taiir_pkg and the core.
// Stimulus is a short directed table followed by segmented random sample streams.

module three_axis_iir_lowpass_core_tb;

   // The core is built with its default sizes, and the model below follows the same ones.
   localparam int TAPS        = 4;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_SHIFT  = 28;
   localparam int AXES        = 3;

   // Feed-forward and feedback coefficients in Q4.28. The leading feedback tap is unity and unused.
   localparam int TAP_B [0:TAPS] = '{49182, 196727, 295090, 196727, 49182};
   localparam int TAP_A [0:TAPS] = '{268435456, -897666375, 1137861378, -646753048, 138909497};

   localparam logic signed [15:0] TOP_SAMPLE    = 16'sh7FFF;
   localparam logic signed [15:0] BOTTOM_SAMPLE = 16'sh8000;

   localparam int RANDOM_WORDS = 1530;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE       = 120;

   typedef struct packed {
      taiir_pkg::req_type word;
      logic               typed;
      taiir_pkg::rsp_type want;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   taiir_pkg::req_type  req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   taiir_pkg::rsp_type  rsp_data;

   // The model's own copy of the filter history, one row of taps for each axis.
   logic signed [15:0] past_in  [AXES][TAPS] = '{default: '0};
   logic signed [39:0] past_out [AXES][TAPS] = '{default: '0};

   taiir_pkg::rsp_type filtered_q [$];
   stim_row_type       directed_rows [$];
   int                 accepted_words = 0;
   int                 fault_count    = 0;
   int                 quiet_cycles   = 0;
   bit                 idle_enable    = 1'b1;

   three_axis_iir_lowpass_core #(
      .FILTER_ORDER          (TAPS),
      .HISTORY_FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The accumulator is divided by 2^28, truncated towards zero and clamped to the signed
   // 40-bit range of the history registers.
   function automatic logic signed [39:0] narrow_history(logic signed [127:0] acc);
      logic [127:0] mag;
      logic [127:0] ceiling;
      logic         neg;
      neg     = acc[127];
      mag     = neg ? -acc : acc;
      mag     = mag >> COEF_SHIFT;
      ceiling = neg ? (128'd1 << 39) : ((128'd1 << 39) - 128'd1);
      if (mag > ceiling) mag = ceiling;
      if (neg) mag = -mag;
      return mag[39:0];
   endfunction

   // The history value loses its fraction bits, truncated towards zero, and is clamped to
   // the 16-bit sample range.
   function automatic logic signed [15:0] to_sample(logic signed [39:0] y);
      logic [39:0] mag;
      if (y < 0) begin
         mag = 40'(-y) >> FRAC_BITS;
         if (mag > 40'd32768) mag = 40'd32768;
         mag = -mag;
      end else begin
         mag = 40'(y) >> FRAC_BITS;
         if (mag > 40'd32767) mag = 40'd32767;
      end
      return mag[15:0];
   endfunction

   // Runs one word through the filter model for all three axes, shifting the history
   // whether or not a result word is to be sent.
   function automatic taiir_pkg::rsp_type filter_word(taiir_pkg::req_type w);
      logic signed [15:0]  sample [AXES];
      logic signed [39:0]  fresh [AXES];
      logic signed [127:0] acc;
      logic signed [127:0] scaled;
      logic signed [127:0] fed_back;
      taiir_pkg::rsp_type  r;
      sample[0] = w.x_sample;
      sample[1] = w.y_sample;
      sample[2] = w.z_sample;
      for (int ax = 0; ax < AXES; ax++) begin
         scaled = sample[ax];
         acc    = (scaled <<< FRAC_BITS) * TAP_B[0];
         for (int i = 1; i <= TAPS; i++) begin
            scaled   = past_in[ax][i-1];
            fed_back = past_out[ax][i-1];
            acc      = acc + (scaled <<< FRAC_BITS) * TAP_B[i] - fed_back * TAP_A[i];
         end
         fresh[ax] = narrow_history(acc);
         for (int i = TAPS - 1; i > 0; i--) begin
            past_in[ax][i]  = past_in[ax][i-1];
            past_out[ax][i] = past_out[ax][i-1];
         end
         past_in[ax][0]  = sample[ax];
         past_out[ax][0] = fresh[ax];
      end
      r.x_filtered = to_sample(fresh[0]);
      r.y_filtered = to_sample(fresh[1]);
      r.z_filtered = to_sample(fresh[2]);
      return r;
   endfunction

   function automatic stim_row_type row(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z, logic en, logic typed);
      stim_row_type s;
      s.word.x_sample    = x;
      s.word.y_sample    = y;
      s.word.z_sample    = z;
      s.word.send_enable = en;
      s.typed            = typed;
      s.want             = '0;
      return s;
   endfunction

   task automatic check_field(string name, logic signed [15:0] want_v, logic signed [15:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fault_count++;
      end
   endtask

   // Presents one word from the falling edge and holds it until the core takes it. Idle
   // cycles beforehand lower valid at one falling edge and raise it at a later one.
   task automatic drive_word(taiir_pkg::req_type w);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // The result side is ready most of the time and stalls at random, except during the
   // stretch in which idling is switched off.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !(idle_enable && $urandom_range(99) < 8);
      end
   end

   // Both handshakes are observed at the rising edge. A result word is checked before a
   // new word is predicted, so that the oldest expectation is always the one compared.
   always @(posedge clock) begin
      taiir_pkg::rsp_type got;
      taiir_pkg::rsp_type want_rsp;
      taiir_pkg::rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (filtered_q.size() == 0) begin
               $error("result word arrived with no expectation waiting");
               fault_count++;
            end else begin
               want_rsp = filtered_q.pop_front();
               check_field("x_filtered", want_rsp.x_filtered, got.x_filtered);
               check_field("y_filtered", want_rsp.y_filtered, got.y_filtered);
               check_field("z_filtered", want_rsp.z_filtered, got.z_filtered);
            end
         end
         if (req_valid && req_ready) begin
            predicted = filter_word(req_data);
            // Rows of the table that carry a typed value are held to that value instead.
            if (accepted_words < directed_rows.size() && directed_rows[accepted_words].typed)
               predicted = directed_rows[accepted_words].want;
            if (req_data.send_enable) filtered_q.push_back(predicted);
            accepted_words++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The run is abandoned if no word moves on either channel for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      taiir_pkg::req_type w;
      logic signed [15:0] hold_val [AXES];
      logic signed [15:0] square;
      int                 seg_kind;
      int                 seg_left;
      int                 half_period;
      int                 phase;
      int                 en_pct;
      int                 v;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      // Directed table. From reset the history is all zero, so zero samples can only give
      // zero; the rest covers the extremes, mixed signs, bit patterns, words that only
      // update the history, and steps between the rails.
      directed_rows.push_back(row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
      directed_rows.push_back(row(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0));
      directed_rows.push_back(row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, BOTTOM_SAMPLE, BOTTOM_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, BOTTOM_SAMPLE, BOTTOM_SAMPLE, 1'b0, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, BOTTOM_SAMPLE, 16'sd0, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, TOP_SAMPLE, -16'sd1, 1'b1, 1'b0));
      directed_rows.push_back(row(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1'b0));
      directed_rows.push_back(row(16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0));
      directed_rows.push_back(row(16'sh5555, 16'shAAAA, 16'sh00FF, 1'b1, 1'b0));
      directed_rows.push_back(row(16'shAAAA, 16'sh5555, 16'shFF00, 1'b1, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b0, 1'b0));
      directed_rows.push_back(row(TOP_SAMPLE, TOP_SAMPLE, TOP_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, BOTTOM_SAMPLE, BOTTOM_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, BOTTOM_SAMPLE, BOTTOM_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(BOTTOM_SAMPLE, BOTTOM_SAMPLE, BOTTOM_SAMPLE, 1'b1, 1'b0));
      directed_rows.push_back(row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) drive_word(directed_rows[i].word);

      // Random part, built from segments. Held values, mostly at the rails, give full step
      // responses whose overshoot drives the outputs into saturation; square waves of
      // varying period excite the filter near its corner; noise and small values fill in
      // the rest. A few segments send nothing and only move the history along.
      seg_left    = 0;
      seg_kind    = 0;
      half_period = 1;
      phase       = 0;
      en_pct      = 95;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (seg_left == 0) begin
            seg_kind = $urandom_range(0, 9);
            if (seg_kind <= 2) seg_left = $urandom_range(5, 40);
            else if (seg_kind <= 6) seg_left = $urandom_range(20, 120);
            else seg_left = $urandom_range(10, 60);
            for (int ax = 0; ax < AXES; ax++) begin
               hold_val[ax] = $urandom_range(1) ? TOP_SAMPLE : BOTTOM_SAMPLE;
               if ($urandom_range(3) == 0) hold_val[ax] = 16'($urandom());
            end
            half_period = $urandom_range(1, 20);
            phase       = 0;
            if ($urandom_range(9) == 0) en_pct = 0;
            else if ($urandom_range(3) == 0) en_pct = 50;
            else en_pct = 95;
         end
         seg_left--;

         if (seg_kind <= 2) begin
            w.x_sample = 16'($urandom());
            w.y_sample = 16'($urandom());
            w.z_sample = 16'($urandom());
         end else if (seg_kind <= 6) begin
            w.x_sample = hold_val[0];
            w.y_sample = hold_val[1];
            w.z_sample = hold_val[2];
         end else if (seg_kind <= 8) begin
            square     = ((phase / half_period) % 2 == 1) ? TOP_SAMPLE : BOTTOM_SAMPLE;
            w.x_sample = square;
            w.y_sample = ~square;
            w.z_sample = hold_val[2];
            phase++;
         end else begin
            v          = int'($urandom_range(0, 64)) - 32;
            w.x_sample = 16'(v);
            v          = int'($urandom_range(0, 64)) - 32;
            w.y_sample = 16'(v);
            v          = int'($urandom_range(0, 64)) - 32;
            w.z_sample = 16'(v);
         end
         w.send_enable = ($urandom_range(99) < en_pct);

         // Twice in the run the sender holds back until every pending result word is in.
         if (n == 250 || n == 900) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (filtered_q.size() != 0) @(negedge clock);
         end

         idle_enable = !(n >= 400 && n < 700);
         drive_word(w);
      end

      @(negedge clock);
      req_valid   <= 1'b0;
      idle_enable  = 1'b1;

      // Drain the pending results, then give any stray word time to appear.
      while (filtered_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/taiir_pkg.sv
src/taiir_mac.sv
src/three_axis_iir_lowpass_core.sv
verif/three_axis_iir_lowpass_core_tb.sv
